// ===== hw/rtl/ctag_pkg.sv =====
package ctag_pkg;

   // function codes of an input transaction
   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_CONTENT = 2'd1;
   localparam logic [1:0] FUNC_NAME    = 2'd2;
   localparam logic [1:0] FUNC_FINISH  = 2'd3;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] MIX_MUL_A = 32'h7FEB_352D;
   localparam logic [31:0] MIX_MUL_B = 32'h846C_A68B;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take_item;   // an input transaction is accepted this cycle
      logic step_mul_a;  // first avalanche multiply
      logic load_tag;    // second multiply into the output register
   } cmd_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_val,
                                            input logic [7:0] data_val);
      logic [31:0] c;
      c = crc_val ^ {24'd0, data_val};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

endpackage

// ===== hw/rtl/ctag_ctrl.sv =====
module ctag_ctrl
   import ctag_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX_A,
      ST_MIX_B
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd.take_item  = 1'b0;
      cmd.step_mul_a = 1'b0;
      cmd.load_tag   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (req_func == FUNC_FINISH) begin
                  state_in = ST_MIX_A;
               end
            end
         end
         ST_MIX_A: begin
            cmd.step_mul_a = 1'b1;
            state_in       = ST_MIX_B;
         end
         ST_MIX_B: begin
            if (out_free) begin
               cmd.load_tag = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/ctag_datapath.sv =====
module ctag_datapath
   import ctag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_file_size,
   input  logic [31:0] req_mod_time,
   output logic [31:0] rsp_tag
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] name_ff, name_in;
   logic [31:0] mix_ff, mix_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] comb_t;
   logic [31:0] prod_a;
   logic [31:0] prod_b;

   // combine size, crc, name hash and time
   always_comb begin
      comb_t = req_file_size;
      comb_t = rotl32(comb_t, 5) ^ (crc_ff ^ CRC_INIT);
      comb_t = rotl32(comb_t, 7) ^ name_ff;
      comb_t = rotl32(comb_t, 11) ^ req_mod_time;
   end

   assign prod_a = mix_ff * MIX_MUL_A;
   assign prod_b = mix_ff * MIX_MUL_B;

   // running hashes and avalanche stages
   always_comb begin
      crc_in  = crc_ff;
      name_in = name_ff;
      mix_in  = mix_ff;
      tag_in  = tag_ff;
      if (cmd.take_item) begin
         case (req_func)
            FUNC_START: begin
               crc_in  = CRC_INIT;
               name_in = FNV_BASIS;
            end
            FUNC_CONTENT: begin
               crc_in = crc_byte(crc_ff, req_data_byte);
            end
            FUNC_NAME: begin
               name_in = (name_ff ^ {24'd0, req_data_byte}) * FNV_PRIME;
            end
            FUNC_FINISH: begin
               mix_in  = comb_t ^ (comb_t >> 16);
               crc_in  = CRC_INIT;
               name_in = FNV_BASIS;
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
      if (cmd.step_mul_a) begin
         mix_in = prod_a ^ (prod_a >> 15);
      end
      if (cmd.load_tag) begin
         tag_in = prod_b ^ (prod_b >> 16);
      end
   end

   // hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         name_ff <= FNV_BASIS;
      end else begin
         crc_ff  <= crc_in;
         name_ff <= name_in;
      end
   end

   // mix and output payload
   always_ff @(posedge clock) begin
      mix_ff <= mix_in;
      tag_ff <= tag_in;
   end

   assign rsp_tag = tag_ff;

endmodule

// ===== hw/rtl/content_tag_hash_top.sv =====
// content tag hash: 32-bit tag from a crc-32 of content bytes and an
// fnv-1a hash of name bytes, mixed with size and time on finish.
// input channel req_*: req_func selects start (clear), content byte,
// name byte or finish; req_file_size and req_mod_time are used on finish.
// output channel rsp_*: one rsp_tag transaction per finish transaction.
// start, content and name transactions are accepted back to back. a
// finish transaction runs the combine step, then one step for each
// avalanche multiply; the tag is valid at the output once the last
// multiply step has loaded it into the output register, and req_ready
// is low during the multiply steps.
// the output register lets new byte transactions in while a tag waits;
// if the receiver stalls, a following finish holds in its last multiply
// step until the waiting tag is taken.
// reset (synchronous) sets the crc to all ones, the name hash to the
// fnv offset basis and drops rsp_valid.
module content_tag_hash_top
   import ctag_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_file_size,
   input  logic [31:0] req_mod_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_tag
);

   cmd_type cmd;

   ctag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ctag_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .req_file_size (req_file_size),
      .req_mod_time  (req_mod_time),
      .rsp_tag       (rsp_tag)
   );

   // a finish blocks input during its multiply cycles
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_FINISH)) |=> !req_ready)
      else $error("input accepted during finish");

   // a tag is waiting at the output after a finish
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_FINISH)) |-> ##3 rsp_valid)
      else $error("tag missing after finish");

   // a new tag only comes from the last multiply step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready && cmd.load_tag))
      else $error("tag loaded outside multiply step");

endmodule
